/* hdl/fdss_pkg.sv */
// fdss_pkg: shared widths, types and register codes for the fan duty saturation select block
// no dependencies; imported by every module of the block
`default_nettype none

package fdss_pkg;

   localparam int NUM_FANS = 8;
   localparam int REQ_W    = 16;
   localparam int DUTY_W   = 13;
   localparam int CNT_W    = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [DUTY_W-1:0] DUTY_ONE   = DUTY_W'(4096);
   localparam logic [CNT_W-1:0]  SAT_RESET  = CNT_W'(8);

   typedef logic [REQ_W-1:0]  request_type;
   typedef logic [DUTY_W-1:0] duty_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef request_type request_vec_type [NUM_FANS];
   typedef duty_type    duty_vec_type [NUM_FANS];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_LIMIT = 2'd0,
      CSR_SAT_COUNT  = 2'd1
   } csr_index_type;

   typedef struct packed {
      duty_type  limit;
      count_type sat_count;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/fan_duty_saturation_select_top.sv */
// fan_duty_saturation_select_top: input register, selection logic and result register
// depends on fdss_pkg, fdss_csr and fdss_select
`default_nettype none

// Takes one item of eight requested fan duties (unsigned Q4.12) per cycle while not stalled
// and returns one result of eight duties plus a saturated flag. If at least saturate_count
// requests exceed duty_limit, the saturate_count largest requests (ties to the lower fan) get
// the limit and the rest get 0; otherwise every request is clipped to the limit. duty_limit
// above 4096 acts as 4096. The item lands in the input register when accepted and moves to
// the result register, with the whole comparison network between them, once that register is
// empty or its result is taken, so a new item is taken every cycle while results are taken.
// Register writes are accepted at any time (csr_ready is always high) but must only be made
// while no item is in flight.
module fan_duty_saturation_select_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_0,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_1,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_2,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_3,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_4,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_5,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_6,
   input  wire logic [fdss_pkg::REQ_W-1:0]     req_request_7,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_0,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_1,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_2,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_3,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_4,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_5,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_6,
   output logic [fdss_pkg::DUTY_W-1:0]         rsp_duty_7,
   output logic                                rsp_saturated,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [fdss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdss_pkg::DUTY_W-1:0]    csr_data
);
   import fdss_pkg::*;

   cfg_type         cfg;
   request_vec_type req_vec;
   request_vec_type req_ff, req_in;
   logic            in_valid_ff, in_valid_in;
   duty_vec_type    sel_duty;
   logic            sel_saturated;
   duty_vec_type    rsp_duty_ff, rsp_duty_in;
   logic            rsp_saturated_ff, rsp_saturated_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            accept;

   fdss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_vec[0] = req_request_0;
   assign req_vec[1] = req_request_1;
   assign req_vec[2] = req_request_2;
   assign req_vec[3] = req_request_3;
   assign req_vec[4] = req_request_4;
   assign req_vec[5] = req_request_5;
   assign req_vec[6] = req_request_6;
   assign req_vec[7] = req_request_7;

   // result register moves when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      req_in      = accept ? req_vec : req_ff;
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   fdss_select u_select (
      .request   (req_ff),
      .cfg       (cfg),
      .duty      (sel_duty),
      .saturated (sel_saturated)
   );

   always_comb begin
      rsp_valid_in     = advance ? in_valid_ff : rsp_valid_ff;
      rsp_duty_in      = rsp_duty_ff;
      rsp_saturated_in = rsp_saturated_ff;
      if (advance && in_valid_ff) begin
         rsp_duty_in      = sel_duty;
         rsp_saturated_in = sel_saturated;
      end
   end

   always_ff @(posedge clock) begin
      rsp_duty_ff      <= rsp_duty_in;
      rsp_saturated_ff <= rsp_saturated_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_saturated = rsp_saturated_ff;
   assign rsp_duty_0    = rsp_duty_ff[0];
   assign rsp_duty_1    = rsp_duty_ff[1];
   assign rsp_duty_2    = rsp_duty_ff[2];
   assign rsp_duty_3    = rsp_duty_ff[3];
   assign rsp_duty_4    = rsp_duty_ff[4];
   assign rsp_duty_5    = rsp_duty_ff[5];
   assign rsp_duty_6    = rsp_duty_ff[6];
   assign rsp_duty_7    = rsp_duty_ff[7];

`ifndef SYNTHESIS
   for (genvar g = 0; g < NUM_FANS; g++) begin : g_chk
      a_duty_range: assert property (@(posedge clock) disable iff (reset)
         rsp_valid_ff |-> rsp_duty_ff[g] <= DUTY_ONE)
         else $error("duty above 1.0");
      a_sat_levels: assert property (@(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_saturated_ff && rsp_duty_ff[g] != '0 && rsp_duty_ff[0] != '0
         |-> rsp_duty_ff[g] == rsp_duty_ff[0])
         else $error("saturated result with mixed nonzero duties");
   end
   a_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("stall with empty input register");
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> rsp_valid_ff)
      else $error("item lost between input and result register");
`endif

endmodule

`default_nettype wire

/* hdl/fdss_csr.sv */
// fdss_csr: duty limit and saturation count registers with their write port
// depends on fdss_pkg; feeds the effective limit and count to the selection logic
`default_nettype none

module fdss_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fdss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fdss_pkg::DUTY_W-1:0]   csr_data,
   output fdss_pkg::cfg_type                  cfg
);
   import fdss_pkg::*;

   duty_type  duty_limit_ff, duty_limit_in;
   count_type sat_count_ff, sat_count_in;

   assign csr_ready = 1'b1;

   always_comb begin
      duty_limit_in = duty_limit_ff;
      sat_count_in  = sat_count_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DUTY_LIMIT: duty_limit_in = csr_data;
            CSR_SAT_COUNT:  sat_count_in  = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_limit_ff <= DUTY_ONE;
         sat_count_ff  <= SAT_RESET;
      end else begin
         duty_limit_ff <= duty_limit_in;
         sat_count_ff  <= sat_count_in;
      end
   end

   // limit saturates at a duty of 1.0
   always_comb begin
      cfg.limit     = (duty_limit_ff > DUTY_ONE) ? DUTY_ONE : duty_limit_ff;
      cfg.sat_count = sat_count_ff;
   end

endmodule

`default_nettype wire

/* hdl/fdss_select.sv */
// fdss_select: over-limit count, descending rank and per-fan duty choice for one item
// depends on fdss_pkg; pure combinational logic between the block's input and result registers
`default_nettype none

module fdss_select (
   input  wire fdss_pkg::request_vec_type request,
   input  wire fdss_pkg::cfg_type         cfg,
   output fdss_pkg::duty_vec_type         duty,
   output logic                           saturated
);
   import fdss_pkg::*;

   logic [NUM_FANS-1:0] over_limit;
   count_type           over_count;
   count_type           rank [NUM_FANS];

   always_comb begin
      over_count = '0;
      for (int i = 0; i < NUM_FANS; i++) begin
         over_limit[i] = request[i] > REQ_W'(cfg.limit);
         over_count    = over_count + CNT_W'(over_limit[i]);
      end
      saturated = over_count >= cfg.sat_count;
   end

   // rank = number of fans that beat this one, ties to the lower index
   always_comb begin
      for (int i = 0; i < NUM_FANS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < NUM_FANS; j++) begin
            if (request[j] > request[i] || (request[j] == request[i] && j < i)) begin
               rank[i] = rank[i] + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_FANS; i++) begin
         if (saturated) begin
            duty[i] = (rank[i] < cfg.sat_count) ? cfg.limit : '0;
         end else begin
            duty[i] = over_limit[i] ? cfg.limit : request[i][DUTY_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking testbench for fan_duty_saturation_select_top
// depends on fdss_pkg and the block's RTL; predicts each result from the register copies
// random items, stalls and register settings are drawn with $urandom
module tb_top;
   import fdss_pkg::*;

   typedef logic [NUM_FANS-1:0][REQ_W-1:0]  fan_requests_type;
   typedef logic [NUM_FANS-1:0][DUTY_W-1:0] fan_duties_type;

   typedef struct packed {
      fan_duties_type duty;
      logic           saturated;
   } duty_outcome_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int ITEMS_PER_PHASE = 135;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DUTY_LIMIT;
   duty_type csr_data = '0;
   fan_requests_type drive_req = '0;

   wire req_stall;
   wire rsp_valid;
   wire rsp_saturated;
   wire csr_ready;
   wire [NUM_FANS-1:0][DUTY_W-1:0] rsp_duty;

   fan_requests_type pending_requests[$];
   duty_outcome_type expected_duties[$];

   duty_type  limit_copy;
   count_type count_copy;
   bit item_taken = 0;
   bit idle_on = 1;
   int gap_left = 0;
   int stall_left = 0;
   int mismatches = 0;
   int results_seen = 0;
   int saturated_seen = 0;
   int items_sent = 0;
   int settings_used = 1;

   fan_duty_saturation_select_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_request_0(drive_req[0]),
      .req_request_1(drive_req[1]),
      .req_request_2(drive_req[2]),
      .req_request_3(drive_req[3]),
      .req_request_4(drive_req[4]),
      .req_request_5(drive_req[5]),
      .req_request_6(drive_req[6]),
      .req_request_7(drive_req[7]),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_duty_0(rsp_duty[0]),
      .rsp_duty_1(rsp_duty[1]),
      .rsp_duty_2(rsp_duty[2]),
      .rsp_duty_3(rsp_duty[3]),
      .rsp_duty_4(rsp_duty[4]),
      .rsp_duty_5(rsp_duty[5]),
      .rsp_duty_6(rsp_duty[6]),
      .rsp_duty_7(rsp_duty[7]),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("timeout with %0d results still outstanding", expected_duties.size());
      $display("simulation failed");
      $finish;
   end

   function automatic duty_type clamp_limit(input duty_type limit_reg);
      return (limit_reg > DUTY_ONE) ? DUTY_ONE : limit_reg;
   endfunction

   function automatic duty_outcome_type select_duties(input fan_requests_type req,
                                                      input duty_type limit_reg,
                                                      input count_type sat_count);
      duty_outcome_type outcome;
      duty_type lim;
      int over;
      int rank;
      lim = clamp_limit(limit_reg);
      over = 0;
      for (int k = 0; k < NUM_FANS; k++) begin
         if (req[k] > lim) over++;
      end
      outcome.saturated = (over >= sat_count);
      for (int k = 0; k < NUM_FANS; k++) begin
         if (outcome.saturated) begin
            rank = 0;
            for (int j = 0; j < NUM_FANS; j++) begin
               if (req[j] > req[k] || (req[j] == req[k] && j < k)) rank++;
            end
            outcome.duty[k] = (rank < sat_count) ? lim : '0;
         end else begin
            outcome.duty[k] = (req[k] > lim) ? lim : DUTY_W'(req[k]);
         end
      end
      return outcome;
   endfunction

   task automatic note_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("result %0d %s: expected %0d, got %0d", results_seen, field, want, got);
      end
   endtask

   task automatic queue_item(input fan_requests_type req);
      pending_requests.insert(pending_requests.size(), req);
   endtask

   // driver: holds each item until accepted, then either idles or presents the next one
   always @(negedge clock) begin : driver
      if (!reset && (!req_valid || item_taken)) begin
         item_taken = 0;
         if (gap_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 12);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            drive_req <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: register copies, predictions on acceptance and result checks
   always @(posedge clock) begin : monitor
      duty_outcome_type want;
      if (reset) begin
         limit_copy = DUTY_ONE;
         count_copy = SAT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DUTY_LIMIT: limit_copy = csr_data;
               CSR_SAT_COUNT:  count_copy = csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_duties.insert(expected_duties.size(),
                                   select_duties(drive_req, limit_copy, count_copy));
            item_taken = 1;
            items_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_duties.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("result %0d arrived with no item pending",
                                              results_seen);
            end else begin
               want = expected_duties.pop_front();
               if (want.saturated) saturated_seen++;
               for (int k = 0; k < NUM_FANS; k++) begin
                  if (rsp_duty[k] !== want.duty[k]) begin
                     note_mismatch($sformatf("duty_%0d", k), REQ_W'(want.duty[k]),
                                   REQ_W'(rsp_duty[k]));
                  end
               end
               if (rsp_saturated !== want.saturated) begin
                  note_mismatch("saturated", REQ_W'(want.saturated), REQ_W'(rsp_saturated));
               end
            end
         end
      end
   end

   function automatic fan_requests_type random_requests(input duty_type limit_reg);
      fan_requests_type req;
      int eff;
      int hot;
      eff = int'(clamp_limit(limit_reg));
      hot = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) begin
         for (int k = 0; k < NUM_FANS; k++) req[k] = REQ_W'($urandom_range(0, 65535));
         return req;
      end
      for (int k = 0; k < NUM_FANS; k++) begin
         case ($urandom_range(0, 11))
            0: req[k] = '0;
            1: req[k] = '1;
            2: req[k] = REQ_W'(eff);
            3: req[k] = REQ_W'(eff + 1);
            4, 5: req[k] = (k > 0) ? req[$urandom_range(0, k - 1)]
                                   : REQ_W'($urandom_range(0, 65535));
            default: begin
               if ($urandom_range(0, 3) < hot) req[k] = REQ_W'($urandom_range(eff + 1, 65535));
               else req[k] = REQ_W'($urandom_range(0, eff));
            end
         endcase
      end
      return req;
   endfunction

   function automatic fan_requests_type tied_requests(input duty_type limit_reg);
      fan_requests_type req;
      for (int k = 0; k < NUM_FANS; k++) begin
         req[k] = (k % 2 == 0) ? '1 : REQ_W'(clamp_limit(limit_reg) + 1);
      end
      return req;
   endfunction

   function automatic fan_requests_type uniform_requests(input logic [REQ_W-1:0] value);
      fan_requests_type req;
      for (int k = 0; k < NUM_FANS; k++) req[k] = value;
      return req;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input duty_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_for_drain;
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_duties.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input duty_type limit_value, input count_type count_value,
                            input bit with_idle);
      wait_for_drain();
      if ($urandom_range(0, 1) == 0) begin
         write_reg(($urandom_range(0, 1) == 0) ? CSR_SPARE_A : CSR_SPARE_B,
                   DUTY_W'($urandom_range(0, 8191)));
      end
      write_reg(CSR_DUTY_LIMIT, limit_value);
      write_reg(CSR_SAT_COUNT, {(DUTY_W - CNT_W)'($urandom_range(0, 511)), count_value});
      settings_used++;
      idle_on = with_idle;
      queue_item(tied_requests(limit_value));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         queue_item(random_requests(limit_value));
      end
   endtask

   initial begin : stimulus
      fan_requests_type req;
      duty_type  limit_set[7] = '{13'd0, 13'd8191, 13'd1, 13'd4096, 13'd2048, 13'd4097,
                                  13'd4095};
      count_type count_set[7] = '{4'd4, 4'd3, 4'd0, 4'd9, 4'd15, 4'd1, 4'd8};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: limit of one, all eight fans needed to saturate
      queue_item(uniform_requests(16'h0000));
      queue_item(uniform_requests(16'hFFFF));
      queue_item(uniform_requests(16'd4096));
      queue_item(uniform_requests(16'd4097));
      req = uniform_requests(16'd4097);
      req[3] = '0;
      queue_item(req);
      for (int k = 0; k < NUM_FANS; k++) req[k] = (k % 2 == 0) ? 16'hAAAA : 16'h5555;
      queue_item(req);
      for (int k = 0; k < NUM_FANS; k++) req[k] = REQ_W'(k * 8192 + 1);
      queue_item(req);
      for (int k = 0; k < NUM_FANS; k++) req[k] = REQ_W'(4094 + k);
      queue_item(req);

      for (int p = 0; p < 7; p++) begin
         run_phase(limit_set[p], count_set[p], $urandom_range(0, 3) != 0);
      end
      for (int p = 0; p < 5; p++) begin
         run_phase(($urandom_range(0, 3) == 0) ? DUTY_W'($urandom_range(4097, 8191))
                                               : DUTY_W'($urandom_range(1, 4096)),
                   CNT_W'($urandom_range(0, 9)), p != 4 && $urandom_range(0, 3) != 0);
      end
      wait_for_drain();

      $display("%0d items checked over %0d register settings, %0d results saturated",
               items_sent, settings_used, saturated_seen);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0 && expected_duties.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
